### rtl/core/aes_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// aes_pkg
// Shared types, constants and byte-level round functions for the AES
// block encryption pipeline.
// ============================================================================
package aes_pkg;

    // Default round count of the pipeline and key lengths in words.
    localparam int          MAX_ROUNDS_DEF = 14;
    localparam logic [3:0]  NK_128         = 4'd4;
    localparam logic [3:0]  NK_192         = 4'd6;
    localparam logic [3:0]  NK_256         = 4'd8;
    localparam logic [3:0]  NR_EXTRA       = 4'd6;

    // Key length codes in bytes.
    localparam logic [5:0]  KLEN_128       = 6'd16;
    localparam logic [5:0]  KLEN_192       = 6'd24;
    localparam logic [5:0]  KLEN_256       = 6'd32;

    // Configuration register indexes.
    localparam logic [2:0]  REG_KEY_LEN    = 3'd0;
    localparam logic [2:0]  REG_KEY_W0     = 3'd1;
    localparam logic [2:0]  REG_KEY_W1     = 3'd2;
    localparam logic [2:0]  REG_KEY_W2     = 3'd3;
    localparam logic [2:0]  REG_KEY_W3     = 3'd4;

    // One pipeline slot: the block state plus the sliding key window.
    // The window holds the last eight expanded key words, oldest at index 0.
    typedef struct packed {
        logic             valid;
        logic             bad;
        logic [127:0]     state;
        logic [7:0][31:0] win;
        logic [2:0]       pos;
        logic [7:0]       rc;
    } t_cell;

    // Forward S-box, entry 0 in the top byte.
    localparam logic [2047:0] SBOX_TBL = {
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,
        8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
        8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,
        8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,
        8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
        8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,
        8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,
        8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
        8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,
        8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,
        8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
        8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,
        8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,
        8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
        8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,
        8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,
        8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] sbox(input logic [7:0] a);
        return SBOX_TBL[11'd2047 - {a, 3'b000} -: 8];
    endfunction

    // Multiply by x in GF(2^8).
    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    // State byte i (row i%4, column i/4) sits at bits 127-8i downward.
    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] t;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                t[127 - 8 * (r + 4 * c) -: 8] =
                    sbox(s[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8]);
            end
        end
        return t;
    endfunction

    function automatic logic [31:0] mix_column(input logic [31:0] w);
        logic [7:0] a0, a1, a2, a3;
        a0 = w[31:24];
        a1 = w[23:16];
        a2 = w[15:8];
        a3 = w[7:0];
        return {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
                a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
                a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
                xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
    endfunction

endpackage

### rtl/core/aes_block_encrypt.sv
`timescale 1ns / 1ps
// ============================================================================
// aes_block_encrypt
// Pipelined AES-128/192/256 forward block encryption.
// ============================================================================
// The block takes one 128-bit plaintext request per cycle and returns its
// ciphertext through an entry register and a chain of round cells, one per
// round, each carrying the block and its own key expansion window. Shorter
// keys run the trailing cells as pass stages, so latency does not depend on
// key length. The whole chain stalls when the output request is held, and
// then no request is taken either. A key length other than 16, 24 or 32
// bytes gives a zero ciphertext with tuser set. Key and length must be
// written only while no request is in flight.
module aes_block_encrypt import aes_pkg::*; #(
    parameter int MAX_ROUNDS = MAX_ROUNDS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Configuration write port.
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_index,
    input  logic [63:0]  i_cfg_data,
    // Input stream.
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // plaintext_low, plaintext_high
    // Output stream.
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,   // ciphertext_low, ciphertext_high
    output logic [0:0]   m_axis_tuser    // bad_key_length
);

    logic [5:0]  r_key_len;
    logic [63:0] r_key [4];

    logic [3:0]  nk;
    logic [3:0]  nr;
    logic        bad;
    logic        en;
    logic [31:0] kw [8];

    t_cell       n_s0;
    t_cell       r_s0;
    t_cell       chain [MAX_ROUNDS + 1];

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_len <= KLEN_128;
            for (int k = 0; k < 4; k++) begin
                r_key[k] <= 64'h0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_KEY_LEN: r_key_len <= i_cfg_data[5:0];
                REG_KEY_W0:  r_key[0]  <= i_cfg_data;
                REG_KEY_W1:  r_key[1]  <= i_cfg_data;
                REG_KEY_W2:  r_key[2]  <= i_cfg_data;
                REG_KEY_W3:  r_key[3]  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Key length decode.
    assign nk  = r_key_len[5:2];
    assign nr  = nk + NR_EXTRA;
    assign bad = !(r_key_len == KLEN_128 || r_key_len == KLEN_192 ||
                   r_key_len == KLEN_256) || (32'(nr) > MAX_ROUNDS);

    // The whole chain advances unless a finished result is held.
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // Entry stage: load the key window and add the first round key.
    // The first four key words always form the first round key.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            kw[2 * k]     = r_key[k][63:32];
            kw[2 * k + 1] = r_key[k][31:0];
        end
        n_s0.valid = s_axis_tvalid;
        n_s0.bad   = bad;
        n_s0.pos   = 3'd0;
        n_s0.rc    = 8'h01;
        for (int k = 0; k < 8; k++) begin
            case (nk)
                NK_128:  n_s0.win[k] = (k >= 4) ? kw[k - 4] : 32'h0;
                NK_192:  n_s0.win[k] = (k >= 2) ? kw[k - 2] : 32'h0;
                default: n_s0.win[k] = kw[k];
            endcase
        end
        n_s0.state = {s_axis_tdata[63:0], s_axis_tdata[127:64]} ^
                     {kw[0], kw[1], kw[2], kw[3]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0.valid <= 1'b0;
        end else if (en) begin
            r_s0 <= n_s0;
        end
    end

    assign chain[0] = r_s0;

    // Chain of round cells.
    for (genvar g = 1; g <= MAX_ROUNDS; g++) begin : g_round
        aes_round_cell #(
            .ROUND (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_nk    (nk),
            .i_nr    (nr),
            .i_cell  (chain[g - 1]),
            .o_cell  (chain[g])
        );
    end

    // Output request from the last cell.
    assign m_axis_tvalid = chain[MAX_ROUNDS].valid;
    assign m_axis_tuser  = chain[MAX_ROUNDS].bad;
    assign m_axis_tdata  = chain[MAX_ROUNDS].bad ? 128'h0 :
                           {chain[MAX_ROUNDS].state[63:0],
                            chain[MAX_ROUNDS].state[127:64]};

endmodule

### rtl/core/aes_round_cell.sv
`timescale 1ns / 1ps
// ============================================================================
// aes_round_cell
// One cipher round plus four steps of key expansion, registered.
// ============================================================================
module aes_round_cell import aes_pkg::*; #(
    parameter int ROUND = 1
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic [3:0] i_nk,
    input  logic [3:0] i_nr,
    input  t_cell      i_cell,
    output t_cell      o_cell
);

    t_cell r_cell;
    t_cell n_cell;

    logic [31:0]  e [12];
    logic [31:0]  tmp;
    logic [31:0]  prev;
    logic [2:0]   pos;
    logic [7:0]   rc;
    logic [127:0] sr;
    logic [127:0] mc;
    logic [127:0] rk;

    // Expand four key words, then apply the round to the state.
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            e[k] = i_cell.win[k];
        end
        pos = i_cell.pos;
        rc  = i_cell.rc;
        for (int k = 0; k < 4; k++) begin
            tmp = e[7 + k];
            if (pos == 3'd0) begin
                tmp = sub_word({tmp[23:0], tmp[31:24]}) ^ {rc, 24'h0};
                rc  = xt(rc);
            end else if (i_nk == NK_256 && pos == 3'd4) begin
                tmp = sub_word(tmp);
            end
            case (i_nk)
                NK_128:  prev = e[4 + k];
                NK_192:  prev = e[2 + k];
                default: prev = e[k];
            endcase
            e[8 + k] = prev ^ tmp;
            pos = (pos == 3'(i_nk - 4'd1)) ? 3'd0 : pos + 3'd1;
        end

        // Round key words sit a fixed distance behind the newest word.
        for (int k = 0; k < 4; k++) begin
            case (i_nk)
                NK_128:  rk[127 - 32 * k -: 32] = e[8 + k];
                NK_192:  rk[127 - 32 * k -: 32] = e[6 + k];
                default: rk[127 - 32 * k -: 32] = e[4 + k];
            endcase
        end

        sr = sub_shift(i_cell.state);
        for (int c = 0; c < 4; c++) begin
            mc[127 - 32 * c -: 32] = mix_column(sr[127 - 32 * c -: 32]);
        end

        n_cell = i_cell;
        if (4'(ROUND) <= i_nr) begin
            n_cell.state = ((4'(ROUND) == i_nr) ? sr : mc) ^ rk;
            for (int k = 0; k < 8; k++) begin
                n_cell.win[k] = e[4 + k];
            end
            n_cell.pos = pos;
            n_cell.rc  = rc;
        end
    end

    // Stage register; only the valid flag needs a reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule

### tb/aes_block_encrypt_test.sv
`timescale 1ns / 1ps
// ============================================================================
// aes_block_encrypt_test
// Self-checking bench for the pipelined AES block encryption core. Random
// and directed plaintext requests go in through the input stream. A local
// AES model predicts the ciphertext or the bad-length flag for each one.
// Every returned request is compared field by field with the oldest
// prediction. Key lengths (valid and invalid) and key words change between
// phases, and only while the pipeline is empty. Both stream sides idle at
// varying rates.
// ============================================================================
module aes_block_encrypt_test;
    import aes_pkg::*;

    localparam int ROUND_LIMIT = MAX_ROUNDS_DEF;
    localparam int DRAIN_CYCLES = MAX_ROUNDS_DEF + 8;

    typedef struct {
        logic [63:0] hi;
        logic [63:0] lo;
        logic        bad;
    } t_cipher;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_cfg_we = 1'b0;
    logic [2:0]    i_cfg_index = REG_KEY_LEN;
    logic [63:0]   i_cfg_data = '0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [127:0]  s_axis_tdata = '0;    // plaintext_low, plaintext_high
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [127:0]  m_axis_tdata;         // ciphertext_low, ciphertext_high
    logic [0:0]    m_axis_tuser;         // bad_key_length

    // Local copy of the key configuration and the S-box.
    logic [5:0]    key_len_bytes;
    logic [63:0]   key_word [4];
    logic [7:0]    sub_tbl [256];

    t_cipher       pending_cipher [$];
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    int            mismatches = 0;
    int            blocks_sent = 0;
    int            blocks_checked = 0;
    int            bad_len_checked = 0;
    int            key_settings = 0;

    aes_block_encrypt dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("Timeout with %0d requests still expected.", pending_cipher.size());
        $display("aes_block_encrypt_test NOT OK");
        $finish;
    end

    // GF(2^8) arithmetic for building the S-box.
    function automatic logic [7:0] gf_double(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        r = 8'h00;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) r ^= a;
            a = gf_double(a);
        end
        return r;
    endfunction

    function automatic logic [7:0] affine_of_inverse(input logic [7:0] a);
        logic [7:0] inv, p, s;
        inv = 8'h01;
        p = a;
        for (int e = 0; e < 8; e++) begin
            if (e != 0) inv = gf_mul(inv, p);   // a^254 = product of a^2..a^128
            p = gf_mul(p, p);
        end
        if (a == 8'h00) inv = 8'h00;
        s = inv;
        for (int k = 1; k <= 4; k++) s ^= (inv << k) | (inv >> (8 - k));
        return s ^ 8'h63;
    endfunction

    function automatic logic [31:0] sub_bytes_word(input logic [31:0] w);
        return {sub_tbl[w[31:24]], sub_tbl[w[23:16]], sub_tbl[w[15:8]], sub_tbl[w[7:0]]};
    endfunction

    // Full AES forward encryption with the current key setting.
    function automatic t_cipher encrypt_block(input logic [63:0] hi, input logic [63:0] lo);
        t_cipher      res;
        logic [31:0]  rk [60];
        logic [31:0]  tmp;
        logic [7:0]   st [16];
        logic [7:0]   sh [16];
        logic [7:0]   rcon, a0, a1, a2, a3;
        logic [127:0] blk;
        int           nk, nr;
        res.hi = '0;
        res.lo = '0;
        res.bad = 1'b1;
        if (key_len_bytes != KLEN_128 && key_len_bytes != KLEN_192 &&
            key_len_bytes != KLEN_256)
            return res;
        nk = key_len_bytes / 4;
        nr = nk + 6;
        if (nr > ROUND_LIMIT) return res;
        res.bad = 1'b0;

        // Key expansion.
        rcon = 8'h01;
        for (int i = 0; i < nk; i++)
            rk[i] = (i % 2 == 0) ? key_word[i/2][63:32] : key_word[i/2][31:0];
        for (int i = nk; i < 4 * (nr + 1); i++) begin
            tmp = rk[i-1];
            if (i % nk == 0) begin
                tmp = sub_bytes_word({tmp[23:0], tmp[31:24]}) ^ {rcon, 24'h0};
                rcon = gf_double(rcon);
            end else if (nk > 6 && i % nk == 4) begin
                tmp = sub_bytes_word(tmp);
            end
            rk[i] = rk[i-nk] ^ tmp;
        end

        // Byte i is row i%4, column i/4.
        blk = {hi, lo};
        for (int i = 0; i < 16; i++)
            st[i] = blk[127-8*i -: 8] ^ rk[i/4][31-8*(i%4) -: 8];

        for (int rnd = 1; rnd <= nr; rnd++) begin
            for (int r = 0; r < 4; r++)
                for (int c = 0; c < 4; c++)
                    sh[r+4*c] = sub_tbl[st[r+4*((c+r)%4)]];
            for (int c = 0; c < 4; c++) begin
                a0 = sh[4*c]; a1 = sh[4*c+1]; a2 = sh[4*c+2]; a3 = sh[4*c+3];
                if (rnd < nr) begin
                    st[4*c]   = gf_double(a0) ^ gf_double(a1) ^ a1 ^ a2 ^ a3;
                    st[4*c+1] = a0 ^ gf_double(a1) ^ gf_double(a2) ^ a2 ^ a3;
                    st[4*c+2] = a0 ^ a1 ^ gf_double(a2) ^ gf_double(a3) ^ a3;
                    st[4*c+3] = gf_double(a0) ^ a0 ^ a1 ^ a2 ^ gf_double(a3);
                end else begin
                    st[4*c] = a0; st[4*c+1] = a1; st[4*c+2] = a2; st[4*c+3] = a3;
                end
            end
            for (int i = 0; i < 16; i++)
                st[i] ^= rk[4*rnd + i/4][31-8*(i%4) -: 8];
        end

        for (int i = 0; i < 8; i++) begin
            res.hi[63-8*i -: 8] = st[i];
            res.lo[63-8*i -: 8] = st[8+i];
        end
        return res;
    endfunction

    // Output side: random backpressure.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Compare each returned request with the oldest prediction.
    always @(posedge i_clk) begin
        t_cipher want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_cipher.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: tdata=%h tuser=%b", m_axis_tdata, m_axis_tuser);
            end else begin
                want = pending_cipher.pop_front();
                blocks_checked++;
                if (want.bad) bad_len_checked++;
                if (m_axis_tdata[63:0] !== want.hi || m_axis_tdata[127:64] !== want.lo ||
                    m_axis_tuser[0] !== want.bad) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch at result %0d: expected hi=%h lo=%h bad=%b, got hi=%h lo=%h bad=%b",
                                 blocks_checked, want.hi, want.lo, want.bad,
                                 m_axis_tdata[63:0], m_axis_tdata[127:64], m_axis_tuser[0]);
                end
            end
        end
    end

    // Register write; the local key copy follows the same decoding.
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        if (idx == REG_KEY_LEN) key_len_bytes = data[5:0];
        else if (idx <= REG_KEY_W3) key_word[idx - REG_KEY_W0] = data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Send one plaintext request, with random idle cycles ahead of it.
    task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {lo, hi};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_cipher.push_back(encrypt_block(hi, lo));
        blocks_sent++;
    endtask

    // Hold off until the pipeline has emptied.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_cipher.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_key(input logic [5:0] len, input logic [63:0] w0,
                            input logic [63:0] w1, input logic [63:0] w2,
                            input logic [63:0] w3);
        wait_idle();
        write_reg(REG_KEY_LEN, {58'h0, len});
        write_reg(REG_KEY_W0, w0);
        write_reg(REG_KEY_W1, w1);
        write_reg(REG_KEY_W2, w2);
        write_reg(REG_KEY_W3, w3);
        key_settings++;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Blocks with the reset key: 128-bit all-zero key.
    task automatic test_reset_key();
        send_block('0, '0);
        send_block('1, '1);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
    endtask

    // Standard test vectors for each key length, plus extreme key values.
    task automatic test_key_lengths();
        load_key(KLEN_128, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, '1, '1);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
        load_key(KLEN_192, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                 64'h1011121314151617, '1);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
        load_key(KLEN_256, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                 64'h1011121314151617, 64'h18191a1b1c1d1e1f);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block('0, '1);
        load_key(KLEN_256, '1, '1, '1, '1);
        send_block('1, '0);
        send_block('0, '0);
    endtask

    // Invalid lengths give a zero block with the flag set.
    task automatic test_bad_lengths();
        load_key(6'd0, '1, '1, '1, '1);
        send_block('1, '1);
        wait_idle();
        write_reg(REG_KEY_LEN, '1);     // only the low six bits are kept
        send_block(rand64(), rand64());
        load_key(6'd20, rand64(), rand64(), rand64(), rand64());
        send_block(rand64(), rand64());
        load_key(6'd33 - 6'd1 - 6'd1, rand64(), rand64(), rand64(), rand64());
        send_block(rand64(), rand64());
    endtask

    // Writes to indexes past the last register must not disturb the key.
    task automatic test_unknown_index();
        load_key(KLEN_192, rand64(), rand64(), rand64(), rand64());
        write_reg(3'd5, '1);
        write_reg(3'd6, '0);
        write_reg(3'd7, rand64());
        send_block(rand64(), rand64());
        send_block('1, '0);
    endtask

    // Random blocks under a series of random key settings.
    task automatic test_random_traffic(input int count, input int s_pct, input int r_pct);
        int sel;
        logic [5:0] len;
        logic [63:0] hi, lo;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0) begin
                sel = $urandom_range(9);
                if (sel < 3) len = KLEN_128;
                else if (sel < 6) len = KLEN_192;
                else if (sel < 8) len = KLEN_256;
                else len = 6'($urandom_range(63));
                load_key(len, rand64(), rand64(), rand64(), rand64());
            end
            sel = $urandom_range(19);
            hi = (sel == 0) ? '0 : (sel == 1) ? '1 : rand64();
            lo = (sel == 2) ? '0 : (sel == 3) ? '1 : rand64();
            send_block(hi, lo);
        end
    endtask

    initial begin
        for (int i = 0; i < 256; i++) sub_tbl[i] = affine_of_inverse(i[7:0]);
        key_len_bytes = KLEN_128;
        foreach (key_word[i]) key_word[i] = '0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_key();
        test_key_lengths();
        test_bad_lengths();
        test_unknown_index();
        test_random_traffic(560, 7, 82);
        test_random_traffic(560, 82, 7);
        test_random_traffic(560, 0, 0);

        wait_idle();
        $display("Checked %0d of %0d blocks over %0d key settings; %0d had a bad key length.",
                 blocks_checked, blocks_sent, key_settings, bad_len_checked);
        $display("Mismatches: %0d", mismatches);
        if (mismatches == 0) begin
            $display("aes_block_encrypt_test OK");
        end else begin
            $display("aes_block_encrypt_test NOT OK");
        end
        $finish;
    end

endmodule
